// ----- hdl/fmhp_pkg.sv -----
// Package for the framed message header parser.
// Holds phase codes, status codes, register indexes and reset values.
// No dependencies; imported by the parser, both checkers and the testbench.
package fmhp_pkg;

  // Width of the frame byte counter; prefixes above its range are rejected.
  localparam int unsigned FrameCountBits = 24;
  localparam logic [32:0] FrameCap = (33'd1 << FrameCountBits) - 33'd1;

  // Configuration port.
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [CfgIdxBits-1:0] CfgMaxFrame    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgPrioLow     = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgPrioHigh    = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgPrioDefault = 2'd3;

  localparam logic [23:0] MaxFrameReset   = 24'(8 * 1024 * 1024);
  localparam logic [7:0]  PrioLowReset    = 8'd0;
  localparam logic [7:0]  PrioHighReset   = 8'd3;
  localparam logic [7:0]  PrioDefaultReset = 8'd2;

  // Parse phases; the phase is also the field code of the result.
  localparam logic [3:0] PhPrefix  = 4'd0;
  localparam logic [3:0] PhMagic   = 4'd1;
  localparam logic [3:0] PhVersion = 4'd2;
  localparam logic [3:0] PhType    = 4'd3;
  localparam logic [3:0] PhSeq     = 4'd4;
  localparam logic [3:0] PhTime    = 4'd5;
  localparam logic [3:0] PhSrcLen  = 4'd6;
  localparam logic [3:0] PhSrcStr  = 4'd7;
  localparam logic [3:0] PhDstLen  = 4'd8;
  localparam logic [3:0] PhDstStr  = 4'd9;
  localparam logic [3:0] PhPrio    = 4'd10;
  localparam logic [3:0] PhSize    = 4'd11;
  localparam logic [3:0] PhSum     = 4'd12;
  localparam logic [3:0] PhPayload = 4'd13;
  localparam logic [3:0] PhTrail   = 4'd14;

  // Frame status codes.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadLen   = 2'd1;
  localparam logic [1:0] StTrunc    = 2'd2;
  localparam logic [1:0] StOversize = 2'd3;

  // Number of bytes in each fixed-size big-endian field.
  function automatic logic [3:0] field_bytes(input logic [3:0] phase);
    logic [3:0] n;
    unique case (phase)
      PhPrefix, PhMagic, PhSeq, PhSize, PhSum: n = 4'd4;
      PhVersion, PhType:                       n = 4'd2;
      PhTime:                                  n = 4'd8;
      PhSrcLen, PhDstLen, PhPrio:              n = 4'd1;
      default:                                 n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/framed_message_header_parser.sv -----
// Top level of the framed message header parser.
// Depends on fmhp_pkg for phase and status codes and register resets.
//
// The parser takes one byte of a length-prefixed frame stream per item and
// returns one result item per byte: the byte, its field code, the value
// assembled so far, and the frame status. It accepts a new byte in every
// cycle while the result side is not stalled; a byte passes an input
// register and then the phase logic writes the result register, once the
// result side can take it. The sustained rate of one item per cycle, when
// the result side does not stall, is set by the parse state update.
// Stalls on the result side back up into the input register before input
// ready falls. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i and take effect for the next byte.
module framed_message_header_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fmhp_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [fmhp_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          stream_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          byte_echo_o,
  output logic [3:0]                          field_code_o,
  output logic [63:0]                         field_value_o,
  output logic                                field_done_o,
  output logic                                frame_end_o,
  output logic [1:0]                          frame_status_o
);
  import fmhp_pkg::*;

  // Configuration registers.
  logic [23:0] max_frame_q;
  logic [7:0]  prio_low_q, prio_high_q, prio_default_q;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Parse state.
  logic [3:0]                phase_q, phase_d;
  logic [7:0]                bif_q, bif_d;
  logic [7:0]                slen_q, slen_d;
  logic [FrameCountBits-1:0] frem_q, frem_d;
  logic [63:0]               acc_q, acc_d;
  logic [31:0]               prem_q, prem_d;
  logic [1:0]                err_q, err_d;

  // Result register.
  logic        out_vld_q;
  logic [7:0]  echo_q;
  logic [3:0]  code_q, code_d;
  logic [63:0] value_q, value_d;
  logic        done_q, done_d;
  logic        end_q, end_d;
  logic [1:0]  status_q;

  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q    <= MaxFrameReset;
      prio_low_q     <= PrioLowReset;
      prio_high_q    <= PrioHighReset;
      prio_default_q <= PrioDefaultReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxFrame:    max_frame_q    <= cfg_data_i[23:0];
        CfgPrioLow:     prio_low_q     <= cfg_data_i[7:0];
        CfgPrioHigh:    prio_high_q    <= cfg_data_i[7:0];
        CfgPrioDefault: prio_default_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  always_comb begin
    logic [7:0]                b;
    logic [7:0]                bif_inc;
    logic [31:0]               len;
    logic                      len_bad;
    logic                      last;
    logic [FrameCountBits-1:0] frem_dec;
    logic [3:0]                np;
    logic [63:0]               acc_sh;
    logic [31:0]               prem_dec;
    logic                      prio_bad;

    b        = in_byte_q;
    bif_inc  = bif_q + 8'd1;
    len      = {acc_q[23:0], b};
    len_bad  = (len == 32'd0) || (len > {8'd0, max_frame_q}) || ({1'b0, len} > FrameCap);
    last     = (frem_q[FrameCountBits-1:1] == '0);
    frem_dec = last ? '0 : frem_q - FrameCountBits'(1);
    acc_sh   = {acc_q[55:0], b};
    prem_dec = (prem_q != 32'd0) ? prem_q - 32'd1 : 32'd0;
    prio_bad = (b < prio_low_q) || (b > prio_high_q);
    np       = phase_q;

    phase_d = phase_q;
    bif_d   = bif_q;
    slen_d  = slen_q;
    frem_d  = frem_q;
    acc_d   = acc_q;
    prem_d  = prem_q;
    err_d   = err_q;
    code_d  = phase_q;
    value_d = 64'd0;
    done_d  = 1'b0;
    end_d   = 1'b0;

    if (phase_q == PhPrefix || phase_q > PhTrail) begin
      code_d  = PhPrefix;
      if (bif_q == 8'd0) err_d = StOk;
      value_d = 64'(len);
      acc_d   = 64'(len);
      bif_d   = bif_inc;
      phase_d = PhPrefix;
      if (bif_inc >= {4'd0, field_bytes(PhPrefix)}) begin
        done_d = 1'b1;
        bif_d  = 8'd0;
        acc_d  = 64'd0;
        if (len_bad) begin
          err_d = StBadLen;
          end_d = 1'b1;
        end else begin
          frem_d  = len[FrameCountBits-1:0];
          phase_d = PhMagic;
        end
      end
    end else begin
      frem_d = frem_dec;
      case (phase_q)
        PhSrcLen, PhDstLen: begin
          value_d = 64'(b);
          done_d  = 1'b1;
          slen_d  = b;
          bif_d   = 8'd0;
          // An empty id skips its string phase.
          np      = (b != 8'd0) ? phase_q + 4'd1 : phase_q + 4'd2;
        end
        PhSrcStr, PhDstStr: begin
          value_d = 64'(bif_q);
          bif_d   = bif_inc;
          if (bif_inc >= slen_q || bif_inc == 8'd0) begin
            bif_d = 8'd0;
            np    = phase_q + 4'd1;
          end
        end
        PhPrio: begin
          value_d = 64'(prio_bad ? prio_default_q : b);
          done_d  = 1'b1;
          np      = PhSize;
        end
        PhPayload: begin
          value_d = acc_q;
          acc_d   = acc_q + 64'd1;
          prem_d  = prem_dec;
          if (prem_dec == 32'd0) begin
            acc_d = 64'd0;
            np    = PhTrail;
          end
        end
        PhTrail: begin
          value_d = acc_q;
          acc_d   = acc_q + 64'd1;
        end
        default: begin
          value_d = acc_sh;
          acc_d   = acc_sh;
          bif_d   = bif_inc;
          if (bif_inc >= {4'd0, field_bytes(phase_q)}) begin
            done_d = 1'b1;
            bif_d  = 8'd0;
            acc_d  = 64'd0;
            case (phase_q)
              PhSize: begin
                prem_d = acc_sh[31:0];
                np     = PhSum;
              end
              PhSum: begin
                if (prem_q > 32'(frem_dec)) err_d = StOversize;
                np = (prem_q == 32'd0) ? PhTrail : PhPayload;
              end
              PhTime:  np = PhSrcLen;
              default: np = phase_q + 4'd1;
            endcase
          end
        end
      endcase
      phase_d = np;

      // The frame ends here; a header still in progress is truncated.
      if (last) begin
        end_d = 1'b1;
        if (np >= PhMagic && np <= PhSum) err_d = StTrunc;
        phase_d = PhPrefix;
        bif_d   = 8'd0;
        slen_d  = 8'd0;
        frem_d  = '0;
        acc_d   = 64'd0;
        prem_d  = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      bif_q   <= 8'd0;
      slen_q  <= 8'd0;
      frem_q  <= '0;
      acc_q   <= 64'd0;
      prem_q  <= 32'd0;
      err_q   <= StOk;
    end else if (advance) begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      slen_q  <= slen_d;
      frem_q  <= frem_d;
      acc_q   <= acc_d;
      prem_q  <= prem_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      echo_q   <= in_byte_q;
      code_q   <= code_d;
      value_q  <= value_d;
      done_q   <= done_d;
      end_q    <= end_d;
      status_q <= err_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign byte_echo_o    = echo_q;
  assign field_code_o   = code_q;
  assign field_value_o  = value_q;
  assign field_done_o   = done_q;
  assign frame_end_o    = end_q;
  assign frame_status_o = status_q;

endmodule

// ----- hdl/fmhp_checker.sv -----
// Port-level checker for the framed message header parser, bound to the top.
// Depends on fmhp_pkg for field and status codes.
module fmhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  byte_echo_o,
  input logic [3:0]  field_code_o,
  input logic [63:0] field_value_o,
  input logic        field_done_o,
  input logic        frame_end_o,
  input logic [1:0]  frame_status_o
);
  import fmhp_pkg::*;

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_echo_o)
      && $stable(field_code_o) && $stable(field_value_o) && $stable(field_done_o)
      && $stable(frame_end_o) && $stable(frame_status_o))
    else $error("result item changed while stalled");

  // A bad length is only reported on the last byte of a rejected prefix.
  a_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == StBadLen |->
      field_code_o == PhPrefix && field_done_o && frame_end_o)
    else $error("bad length status outside a rejected prefix");

  // Prefix bytes that do not end a rejected prefix carry a clean status.
  a_prefix_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_code_o == PhPrefix && !frame_end_o |-> frame_status_o == StOk)
    else $error("prefix byte with a stale status");

  // A truncated header is reported only on the frame's last byte.
  a_trunc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == StTrunc |->
      frame_end_o && field_code_o != PhPrefix && field_code_o != PhPayload
      && field_code_o != PhTrail)
    else $error("truncated status away from a header frame end");

endmodule

bind framed_message_header_parser fmhp_checker u_fmhp_checker (.*);

// ----- test/header_parse_checker.sv -----
// Checker for the framed message header parser: mirrors register writes, predicts the
// result of every accepted byte and compares it with the result channel.
// Depends on fmhp_pkg for phase codes, status codes, register indexes and resets.
module header_parse_checker
  import fmhp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             stream_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [7:0]             byte_echo_i,
  input  logic [3:0]             field_code_i,
  input  logic [63:0]            field_value_i,
  input  logic                   field_done_i,
  input  logic                   frame_end_i,
  input  logic [1:0]             frame_status_i,
  output int                     mismatch_count_o,
  output int                     outstanding_o,
  output logic                   frame_start_o
);

  typedef struct packed {
    logic [7:0]  echo;
    logic [3:0]  code;
    logic [63:0] value;
    logic        done;
    logic        fend;
    logic [1:0]  status;
  } byte_result_t;

  byte_result_t parsed_bytes_q[$];

  // Register copies.
  logic [23:0] max_frame;
  logic [7:0]  prio_lo;
  logic [7:0]  prio_hi;
  logic [7:0]  prio_dflt;

  // Parser state.
  logic [3:0]  phase;
  logic [7:0]  field_pos;
  logic [7:0]  id_len;
  logic [23:0] frame_left;
  logic [63:0] acc;
  logic [31:0] payload_left;
  logic [1:0]  latched_status;

  function automatic void clear_frame();
    phase        = PhPrefix;
    field_pos    = 8'd0;
    id_len       = 8'd0;
    frame_left   = 24'd0;
    acc          = 64'd0;
    payload_left = 32'd0;
  endfunction

  function automatic logic [7:0] numeric_len(input logic [3:0] ph);
    case (ph)
      PhVersion, PhType: return 8'd2;
      PhTime:            return 8'd8;
      default:           return 8'd4;
    endcase
  endfunction

  function automatic byte_result_t parse_next_byte(input logic [7:0] b);
    byte_result_t r;
    logic         last;
    logic [3:0]   nxt;
    logic [31:0]  len;
    r = '0;
    r.echo = b;
    if (phase == PhPrefix || phase > PhTrail) begin
      r.code = PhPrefix;
      if (field_pos == 8'd0) latched_status = StOk;
      acc = {32'h0, acc[23:0], b};
      field_pos = field_pos + 8'd1;
      r.value = acc;
      phase = PhPrefix;
      if (field_pos >= 8'd4) begin
        r.done = 1'b1;
        field_pos = 8'd0;
        len = acc[31:0];
        acc = 64'd0;
        if (len == 32'd0 || len > {8'h0, max_frame} || {1'b0, len} > FrameCap) begin
          latched_status = StBadLen;
          r.fend = 1'b1;
        end else begin
          frame_left = len[23:0];
          phase = PhMagic;
        end
      end
    end else begin
      r.code = phase;
      last = (frame_left <= 24'd1);
      frame_left = last ? 24'd0 : frame_left - 24'd1;
      nxt = phase;
      case (phase)
        PhSrcLen, PhDstLen: begin
          r.value = {56'h0, b};
          r.done = 1'b1;
          id_len = b;
          field_pos = 8'd0;
          // An empty id skips straight past its string.
          nxt = (b != 8'd0) ? phase + 4'd1 : phase + 4'd2;
        end
        PhSrcStr, PhDstStr: begin
          r.value = {56'h0, field_pos};
          field_pos = field_pos + 8'd1;
          if (field_pos >= id_len || field_pos == 8'd0) begin
            field_pos = 8'd0;
            nxt = phase + 4'd1;
          end
        end
        PhPrio: begin
          r.value = (b < prio_lo || b > prio_hi) ? {56'h0, prio_dflt} : {56'h0, b};
          r.done = 1'b1;
          nxt = PhSize;
        end
        PhPayload: begin
          r.value = acc;
          acc = acc + 64'd1;
          if (payload_left != 32'd0) payload_left = payload_left - 32'd1;
          if (payload_left == 32'd0) begin
            acc = 64'd0;
            nxt = PhTrail;
          end
        end
        PhTrail: begin
          r.value = acc;
          acc = acc + 64'd1;
        end
        default: begin
          acc = {acc[55:0], b};
          field_pos = field_pos + 8'd1;
          r.value = acc;
          if (field_pos >= numeric_len(phase)) begin
            r.done = 1'b1;
            field_pos = 8'd0;
            if (phase == PhSize) begin
              payload_left = acc[31:0];
              nxt = PhSum;
            end else if (phase == PhSum) begin
              // The size is checked against what is left after the checksum.
              if (payload_left > {8'h0, frame_left}) latched_status = StOversize;
              nxt = (payload_left == 32'd0) ? PhTrail : PhPayload;
            end else begin
              nxt = phase + 4'd1;
            end
            acc = 64'd0;
          end
        end
      endcase
      phase = nxt;
      if (last) begin
        r.fend = 1'b1;
        if (nxt >= PhMagic && nxt <= PhSum) latched_status = StTrunc;
        clear_frame();
      end
    end
    r.status = latched_status;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count_o < 100) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    byte_result_t want;
    byte_result_t pred;
    if (!rst_ni) begin
      max_frame = MaxFrameReset;
      prio_lo = PrioLowReset;
      prio_hi = PrioHighReset;
      prio_dflt = PrioDefaultReset;
      clear_frame();
      latched_status = StOk;
      parsed_bytes_q.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
      frame_start_o = 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxFrame:    max_frame = cfg_data_i[23:0];
          CfgPrioLow:     prio_lo = cfg_data_i[7:0];
          CfgPrioHigh:    prio_hi = cfg_data_i[7:0];
          CfgPrioDefault: prio_dflt = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pred = parse_next_byte(stream_byte_i);
        parsed_bytes_q.insert(parsed_bytes_q.size(), pred);
      end
      if (out_valid_i && out_ready_i) begin
        if (parsed_bytes_q.size() == 0) begin
          report_mismatch("result with nothing pending", {56'h0, byte_echo_i}, 64'h0);
        end else begin
          want = parsed_bytes_q.pop_front();
          if (byte_echo_i !== want.echo)
            report_mismatch("byte_echo", {56'h0, byte_echo_i}, {56'h0, want.echo});
          if (field_code_i !== want.code)
            report_mismatch("field_code", {60'h0, field_code_i}, {60'h0, want.code});
          if (field_value_i !== want.value)
            report_mismatch("field_value", field_value_i, want.value);
          if (field_done_i !== want.done)
            report_mismatch("field_done", {63'h0, field_done_i}, {63'h0, want.done});
          if (frame_end_i !== want.fend)
            report_mismatch("frame_end", {63'h0, frame_end_i}, {63'h0, want.fend});
          if (frame_status_i !== want.status)
            report_mismatch("frame_status", {62'h0, frame_status_i}, {62'h0, want.status});
        end
      end
      outstanding_o = parsed_bytes_q.size();
      frame_start_o = (phase == PhPrefix && field_pos == 8'd0);
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the parser testbench: clock, reset, register writes and the byte stream,
// with random gaps on both channels. Uses header_parse_checker to check the results.
// Depends on fmhp_pkg and the framed_message_header_parser RTL.
module testbench;
  import fmhp_pkg::*;

  localparam int StallLimit = 2000;

  // Content of generated header fields.
  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             stream_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             byte_echo;
  logic [3:0]             field_code;
  logic [63:0]            field_value;
  logic                   field_done;
  logic                   frame_end;
  logic [1:0]             frame_status;

  int          mismatches;
  int          outstanding;
  logic        frame_start;

  logic [7:0]  tx_q[$];
  int unsigned cur_max;
  logic [7:0]  cur_lo;
  logic [7:0]  cur_hi;
  logic [7:0]  pick_lo;
  bit          calm = 1'b0;
  int          sink_hold = 0;
  int          idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  framed_message_header_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .stream_byte_i  (stream_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .byte_echo_o    (byte_echo),
    .field_code_o   (field_code),
    .field_value_o  (field_value),
    .field_done_o   (field_done),
    .frame_end_o    (frame_end),
    .frame_status_o (frame_status)
  );

  header_parse_checker i_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .byte_echo_i      (byte_echo),
    .field_code_i     (field_code),
    .field_value_i    (field_value),
    .field_done_i     (field_done),
    .frame_end_i      (frame_end),
    .frame_status_i   (frame_status),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .frame_start_o    (frame_start)
  );

  // Mostly short gaps, a few long ones; none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else begin
      sink_hold = pick_gap();
      out_ready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] fill_byte(input int fill);
    case (fill)
      FillZero: return 8'h00;
      FillOnes: return 8'hFF;
      default:  return 8'($urandom);
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    tx_q.insert(tx_q.size(), b);
  endtask

  task automatic push_word(input logic [31:0] w);
    queue_byte(w[31:24]);
    queue_byte(w[23:16]);
    queue_byte(w[15:8]);
    queue_byte(w[7:0]);
  endtask

  // One frame: fixed header, two ids, priority, size, checksum, payload and
  // trailing bytes. A nonzero cut below the body length shortens the declared length.
  task automatic add_frame(input int slen, input int dlen, input logic [7:0] prio,
                           input logic [31:0] psize, input int pay_n, input int trail_n,
                           input int cut, input int fill);
    logic [7:0] body[$];
    int         len;
    repeat (20) body.insert(body.size(), fill_byte(fill));
    body.insert(body.size(), 8'(slen));
    repeat (slen) body.insert(body.size(), fill_byte(fill));
    body.insert(body.size(), 8'(dlen));
    repeat (dlen) body.insert(body.size(), fill_byte(fill));
    body.insert(body.size(), prio);
    for (int i = 3; i >= 0; i--) body.insert(body.size(), psize[8*i +: 8]);
    repeat (4 + pay_n + trail_n) body.insert(body.size(), fill_byte(fill));
    len = body.size();
    if (cut > 0 && cut < len) len = cut;
    push_word(32'(len));
    for (int i = 0; i < len; i++) queue_byte(body[i]);
  endtask

  function automatic logic [31:0] bad_len();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return cur_max + 1;
      2:       return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
      default: return $urandom_range(cur_max + 1, 32'h00FF_FFFF);
    endcase
  endfunction

  task automatic rand_frame();
    int          kind;
    int          slen;
    int          dlen;
    int          pay_n;
    int          trail_n;
    logic [7:0]  prio;
    logic [31:0] psize;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      push_word(bad_len());
      return;
    end
    slen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
    dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
    pay_n = $urandom_range(0, 8);
    trail_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    case ($urandom_range(0, 4))
      0:       prio = cur_lo - 8'd1;
      1:       prio = cur_lo;
      2:       prio = cur_hi;
      3:       prio = cur_hi + 8'd1;
      default: prio = 8'($urandom);
    endcase
    psize = 32'(pay_n);
    if (kind < 26) begin
      add_frame(slen, dlen, prio, psize, pay_n, trail_n,
                $urandom_range(1, 30 + slen + dlen), FillRandom);
    end else begin
      if (kind < 38) begin
        psize = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                           : 32'(pay_n + trail_n + $urandom_range(1, 300));
      end else if (kind < 46) begin
        psize = 32'(pay_n + trail_n);
      end
      add_frame(slen, dlen, prio, psize, pay_n, trail_n, 0, FillRandom);
    end
  endtask

  task automatic send_bytes();
    int gap;
    while (tx_q.size() > 0) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      stream_byte <= tx_q.pop_front();
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned max_len, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] dflt);
    cfg_we <= 1'b1;
    cfg_idx <= CfgMaxFrame;
    cfg_data <= max_len[23:0];
    @(posedge clk_i);
    cfg_idx <= CfgPrioLow;
    cfg_data <= {16'h0, lo};
    @(posedge clk_i);
    cfg_idx <= CfgPrioHigh;
    cfg_data <= {16'h0, hi};
    @(posedge clk_i);
    cfg_idx <= CfgPrioDefault;
    cfg_data <= {16'h0, dflt};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_max = max_len;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic run_phase(input int unsigned max_len, input logic [7:0] lo,
                           input logic [7:0] hi, input logic [7:0] dflt, input int batch);
    // A rejected frame can leave the stream out of step; feed bytes until the
    // parser expects a fresh prefix.
    while (!frame_start) begin
      queue_byte(8'($urandom));
      send_bytes();
      drain();
    end
    apply_config(max_len, lo, hi, dflt);
    calm = ($urandom_range(0, 3) == 0);
    push_word(cur_max + 1);
    while (tx_q.size() < batch) rand_frame();
    send_bytes();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_config(32'(MaxFrameReset), PrioLowReset, PrioHighReset, PrioDefaultReset);

    push_word(32'd0);
    push_word(32'(MaxFrameReset) + 32'd1);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0100_0000);
    add_frame(0, 0, 8'h00, 32'd0, 0, 0, 0, FillZero);
    add_frame(1, 3, 8'hFF, 32'd2, 2, 2, 0, FillOnes);
    add_frame(2, 2, 8'h03, 32'd0, 0, 0, 1, FillRandom);
    // Cut inside the destination id.
    add_frame(3, 4, 8'h01, 32'd0, 0, 0, 20 + 1 + 3 + 1 + 2, FillRandom);
    add_frame(0, 0, 8'h02, 32'hFFFF_FFFF, 3, 0, 0, FillRandom);
    // The frame ends on the checksum with one payload byte still announced.
    add_frame(0, 0, 8'h04, 32'd1, 0, 0, 0, FillRandom);
    add_frame(24, 0, 8'h01, 32'd1, 1, 0, 0, FillRandom);
    add_frame(0, 1, 8'h05, 32'd0, 0, 5, 0, FillRandom);
    send_bytes();
    drain();

    run_phase(32'(MaxFrameReset), 8'd0, 8'd3, 8'd2, 30);
    run_phase($urandom_range(45, 90), 8'($urandom_range(128, 255)),
              8'($urandom_range(0, 127)), 8'hFF, 30);
    run_phase(1, 8'd0, 8'hFF, 8'd0, 8);
    run_phase(0, 8'hFF, 8'hFF, 8'hFF, 8);
    pick_lo = 8'($urandom_range(0, 100));
    run_phase($urandom_range(200, 32'(MaxFrameReset)), pick_lo,
              8'($urandom_range(pick_lo, 255)), 8'($urandom), 30);

    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fmhp_pkg.sv
hdl/framed_message_header_parser.sv
hdl/fmhp_checker.sv
test/header_parse_checker.sv
test/testbench.sv
